// ===== rtl/core/c3s_pkg.sv =====
// c3s_pkg: shared types and constants of the streaming 3x3 convolution.
// Holds the channel payload structs and the configuration register indexes.
// No dependencies; compile first.
package c3s_pkg;

  localparam int KSIZE          = 3;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int COEF_BITS_DEF  = 16;

  localparam int PIXEL_W    = 8;
  localparam int SIZE_CFG_W = 11;
  localparam int COEF_ROW_W = 48;
  localparam int COEF_SLOT  = 16;
  localparam int POS_W      = 10;
  localparam int CONV_W     = 28;
  localparam int CFG_IDX_W  = 3;

  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;
  localparam int SIZE_MIN   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 3'd0,
    CFG_IMAGE_HEIGHT = 3'd1,
    CFG_COEF_TOP     = 3'd2,
    CFG_COEF_MID     = 3'd3,
    CFG_COEF_BOTTOM  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
  } pix_t;

  typedef struct packed {
    logic        [POS_W-1:0]  out_row;
    logic        [POS_W-1:0]  out_col;
    logic signed [CONV_W-1:0] conv_value;
    logic                     frame_last;
  } res_t;

endpackage

// ===== rtl/core/c3s_stream_if.sv =====
// c3s_stream_if: valid/ready channel carrying one payload of type T.
// Used for the pixel input and the result output; payload types come from c3s_pkg.
interface c3s_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/conv2d_3x3_stream.sv =====
// conv2d_3x3_stream: streaming 3x3 convolution over 8-bit raster pixels.
// Depends on c3s_pkg (types, constants) and c3s_stream_if (channels).
//
//   channel   dir  payload                                   transaction when
//   pix_i     in   pixel[7:0]                                valid && ready
//   res_o     out  out_row, out_col, conv_value, frame_last  valid && ready
//   cfg_*     in   cfg_idx_i, cfg_data_i[47:0]               cfg_we_i high
//
// One pixel per clock sustained while pix_i.ready is high. A result passes the
// line memory read, window, products and row sums stages, then the output
// queue.
// pix_i.ready is registered state only: it drops while the 8-entry result
// queue plus the four pipeline stages would be full, so a stalled sink
// back-pressures the source without any path from res_o.ready to pix_i.ready.
// Reset clears counters, window, pipeline valids and queue; the line memory
// is never cleared, as every entry read in a frame was written one row earlier.
module conv2d_3x3_stream #(
  parameter int MAX_WIDTH  = c3s_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = c3s_pkg::MAX_HEIGHT_DEF,
  parameter int COEF_BITS  = c3s_pkg::COEF_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [c3s_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [c3s_pkg::COEF_ROW_W-1:0]   cfg_data_i,
  c3s_stream_if.sink                       pix_i,
  c3s_stream_if.source                     res_o
);

  localparam int CW   = $clog2(MAX_WIDTH + 1);   // column counter, holds width
  localparam int RHW  = $clog2(MAX_HEIGHT + 1);  // row counter, holds height
  localparam int AW   = $clog2(MAX_WIDTH);       // line memory address
  localparam int PW   = COEF_BITS + c3s_pkg::PIXEL_W + 1;
  localparam int RSW  = PW + 2;
  localparam int TW   = RSW + 2;
  localparam int PXW  = c3s_pkg::PIXEL_W;
  localparam int K    = c3s_pkg::KSIZE;
  localparam int QD   = 8;
  localparam int QAW  = $clog2(QD);
  localparam int QCW  = $clog2(QD + 1);
  localparam int OCW  = QCW + 1;
  localparam int WRst = (c3s_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : c3s_pkg::WIDTH_RST;
  localparam int HRst = (c3s_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT
                                                           : c3s_pkg::HEIGHT_RST;

  typedef struct packed {
    logic [c3s_pkg::POS_W-1:0] row;
    logic [c3s_pkg::POS_W-1:0] col;
    logic                      emit;
    logic                      last;
  } meta_t;

  // ---------------------------------------------------------------------------
  // Configuration registers; sizes are clamped on write
  // ---------------------------------------------------------------------------
  logic [CW-1:0]                  w_q;
  logic [RHW-1:0]                 h_q;
  logic [c3s_pkg::COEF_ROW_W-1:0] coef_q [K];
  logic [c3s_pkg::SIZE_CFG_W-1:0] size_v;

  assign size_v = cfg_data_i[c3s_pkg::SIZE_CFG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q       <= CW'(WRst);
      h_q       <= RHW'(HRst);
      coef_q[0] <= '0;
      coef_q[1] <= '0;
      coef_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        c3s_pkg::CFG_IMAGE_WIDTH: begin
          if (int'(size_v) < c3s_pkg::SIZE_MIN) w_q <= CW'(c3s_pkg::SIZE_MIN);
          else if (int'(size_v) > MAX_WIDTH)     w_q <= CW'(MAX_WIDTH);
          else                                   w_q <= CW'(size_v);
        end
        c3s_pkg::CFG_IMAGE_HEIGHT: begin
          if (int'(size_v) < c3s_pkg::SIZE_MIN) h_q <= RHW'(c3s_pkg::SIZE_MIN);
          else if (int'(size_v) > MAX_HEIGHT)    h_q <= RHW'(MAX_HEIGHT);
          else                                   h_q <= RHW'(size_v);
        end
        c3s_pkg::CFG_COEF_TOP:    coef_q[0] <= cfg_data_i;
        c3s_pkg::CFG_COEF_MID:    coef_q[1] <= cfg_data_i;
        c3s_pkg::CFG_COEF_BOTTOM: coef_q[2] <= cfg_data_i;
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input side: position counters and occupancy-based ready
  // ---------------------------------------------------------------------------
  logic           s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic [QCW-1:0] q_cnt_q;
  logic [OCW-1:0] occ;
  logic           pix_fire;

  // Count every item that may still land in the queue.
  assign occ = OCW'(q_cnt_q) + OCW'(s1_v_q) + OCW'(s2_v_q) + OCW'(s3_v_q) + OCW'(s4_v_q);
  assign pix_i.ready = (occ < OCW'(QD));
  assign pix_fire    = pix_i.valid && pix_i.ready;

  logic [CW-1:0]  col_q, col_d, c_a, c_n;
  logic [RHW-1:0] row_q, row_d, r_t, r_a, r_n;
  logic [RHW-1:0] r_m1;
  logic [CW-1:0]  c_m1;
  meta_t          meta_a;

  always_comb begin
    // Wrap a stale position first (size may have shrunk since the last pixel).
    c_a = (col_q >= w_q) ? '0 : col_q;
    r_t = (col_q >= w_q) ? row_q + 1'b1 : row_q;
    r_a = (r_t >= h_q) ? '0 : r_t;
    // Advance past the current pixel.
    c_n = c_a + 1'b1;
    r_n = r_a + 1'b1;
    if (c_n >= w_q) begin
      col_d = '0;
      row_d = (r_n >= h_q) ? '0 : r_n;
    end else begin
      col_d = c_n;
      row_d = r_a;
    end
    r_m1 = r_a - 1'b1;
    c_m1 = c_a - 1'b1;
    meta_a.row  = c3s_pkg::POS_W'(r_m1);
    meta_a.col  = c3s_pkg::POS_W'(c_m1);
    meta_a.emit = (r_a >= RHW'(2)) && (c_a >= CW'(2));
    meta_a.last = (r_a == h_q - 1'b1) && (c_a == w_q - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: entry holds {row r-1 pixel, row r-2 pixel} of one column.
  // Read on the pixel transaction, written back in the next cycle. Consecutive
  // pixels never share a column (width >= 3), so no forwarding is needed.
  // ---------------------------------------------------------------------------
  logic [2*PXW-1:0] line_mem [MAX_WIDTH];
  logic [2*PXW-1:0] rd_q;
  logic [AW-1:0]    s1_addr_q;
  logic [PXW-1:0]   s1_px_q;
  meta_t            s1_meta_q;

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      rd_q <= line_mem[c_a[AW-1:0]];
    end
    if (s1_v_q) begin
      line_mem[s1_addr_q] <= {s1_px_q, rd_q[2*PXW-1:PXW]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      s1_addr_q <= c_a[AW-1:0];
      s1_px_q   <= pix_i.data.pixel;
      s1_meta_q <= meta_a;
    end
  end

  // ---------------------------------------------------------------------------
  // Window shift (stage 2)
  // ---------------------------------------------------------------------------
  logic [PXW-1:0] win_q [K][K];
  meta_t          s2_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < K; i++) begin
        for (int j = 0; j < K; j++) begin
          win_q[i][j] <= '0;
        end
      end
    end else if (s1_v_q) begin
      for (int i = 0; i < K; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= rd_q[PXW-1:0];
      win_q[1][2] <= rd_q[2*PXW-1:PXW];
      win_q[2][2] <= s1_px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_meta_q <= s1_meta_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Products (stage 3): tap (i,j) uses the flipped coefficient k[2-i][2-j]
  // ---------------------------------------------------------------------------
  logic signed [COEF_BITS-1:0] coef [K][K];
  logic signed [PW-1:0]        prod_q [K][K];
  meta_t                       s3_meta_q;

  always_comb begin
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        coef[i][j] = coef_q[K-1-i][c3s_pkg::COEF_SLOT*(K-1-j) +: COEF_BITS];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q && s2_meta_q.emit) begin
      for (int i = 0; i < K; i++) begin
        for (int j = 0; j < K; j++) begin
          prod_q[i][j] <= $signed({1'b0, win_q[i][j]}) * coef[i][j];
        end
      end
      s3_meta_q <= s2_meta_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Row sums (stage 4), total on the way into the queue
  // ---------------------------------------------------------------------------
  logic signed [RSW-1:0] rsum_q [K];
  logic signed [TW-1:0]  total;
  meta_t                 s4_meta_q;

  always_ff @(posedge clk_i) begin
    if (s3_v_q) begin
      for (int i = 0; i < K; i++) begin
        rsum_q[i] <= RSW'(prod_q[i][0]) + RSW'(prod_q[i][1]) + RSW'(prod_q[i][2]);
      end
      s4_meta_q <= s3_meta_q;
    end
  end

  assign total = TW'(rsum_q[0]) + TW'(rsum_q[1]) + TW'(rsum_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      s1_v_q <= pix_fire;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q && s2_meta_q.emit;  // border pixels stop here
      s4_v_q <= s3_v_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue
  // ---------------------------------------------------------------------------
  c3s_pkg::res_t  q_mem [QD];
  c3s_pkg::res_t  q_in;
  logic [QAW-1:0] q_wr_q, q_rd_q;
  logic           q_push, q_pop;

  assign q_push = s4_v_q;
  assign q_pop  = res_o.valid && res_o.ready;

  always_comb begin
    q_in.out_row    = s4_meta_q.row;
    q_in.out_col    = s4_meta_q.col;
    q_in.conv_value = c3s_pkg::CONV_W'(total);
    q_in.frame_last = s4_meta_q.last;
  end

  always_ff @(posedge clk_i) begin
    if (q_push) begin
      q_mem[q_wr_q] <= q_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= '0;
      q_rd_q  <= '0;
      q_cnt_q <= '0;
    end else begin
      if (q_push) q_wr_q <= q_wr_q + 1'b1;
      if (q_pop)  q_rd_q <= q_rd_q + 1'b1;
      q_cnt_q <= q_cnt_q + QCW'(q_push) - QCW'(q_pop);
    end
  end

  assign res_o.valid = (q_cnt_q != '0);
  assign res_o.data  = q_mem[q_rd_q];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= QCW'(QD))
    else $error("result queue over its depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_cnt_q < QCW'(QD)) || q_pop)
    else $error("push into a full result queue");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_fire |=> s1_v_q)
    else $error("accepted pixel lost before line memory stage");

  a_emit_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_meta_q.emit) |=> ##1 q_push)
    else $error("interior result did not reach the queue");

  a_ready_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.ready |-> (occ < OCW'(QD)))
    else $error("ready raised with queue and pipeline full");

endmodule

// ===== dv/conv3x3_checker.sv =====
// conv3x3_checker: predicts and checks the results of conv2d_3x3_stream.
// Watches the pixel channel, the result channel and the register write port.
// Depends on c3s_pkg for payload types, widths and register indexes.
module conv3x3_checker
  import c3s_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [COEF_ROW_W-1:0] cfg_data_i,
  input  logic                  pix_valid_i,
  input  logic                  pix_ready_i,
  input  pix_t                  pix_data_i,
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  res_t                  res_data_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int REPORT_LINES = 100;

  logic [SIZE_CFG_W-1:0] width_reg;
  logic [SIZE_CFG_W-1:0] height_reg;
  logic [COEF_ROW_W-1:0] coef_rows [KSIZE];
  logic [PIXEL_W-1:0]    line_mem [2][MAX_WIDTH];
  logic [PIXEL_W-1:0]    win [KSIZE][KSIZE];
  int unsigned           row_cnt;
  int unsigned           col_cnt;
  res_t                  expected_results [$];

  function automatic int unsigned clamp_dim(logic [SIZE_CFG_W-1:0] v, int unsigned lim);
    if (v < SIZE_MIN) return SIZE_MIN;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic longint kernel_tap(int kr, int kc);
    logic signed [COEF_SLOT-1:0] slot;
    slot = coef_rows[kr][kc*COEF_SLOT +: COEF_SLOT];
    return longint'(slot);
  endfunction

  task automatic report(input string msg);
    if (fail_count_o < REPORT_LINES) $display("%0t mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  // Wrap the raster position, shift the window, update the line memory and
  // queue the flipped-kernel sum once the window sits over an interior point.
  task automatic take_pixel(input logic [PIXEL_W-1:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned r;
    int unsigned c;
    int          i;
    int          j;
    longint      acc;
    res_t        want;
    w = clamp_dim(width_reg, MAX_WIDTH);
    h = clamp_dim(height_reg, MAX_HEIGHT);
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    r = row_cnt;
    c = col_cnt;
    for (i = 0; i < KSIZE; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = line_mem[0][c];
    win[1][2] = line_mem[1][c];
    win[2][2] = px;
    line_mem[0][c] = line_mem[1][c];
    line_mem[1][c] = px;
    if (r >= KSIZE - 1 && c >= KSIZE - 1) begin
      acc = 0;
      for (i = 0; i < KSIZE; i++) begin
        for (j = 0; j < KSIZE; j++) begin
          acc += longint'(win[i][j]) * kernel_tap(KSIZE - 1 - i, KSIZE - 1 - j);
        end
      end
      want.out_row    = POS_W'(r - 1);
      want.out_col    = POS_W'(c - 1);
      want.conv_value = acc[CONV_W-1:0];
      want.frame_last = (r == h - 1) && (c == w - 1);
      expected_results.push_back(want);
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  task automatic check_result(input res_t got);
    res_t want;
    if (expected_results.size() == 0) begin
      report($sformatf("result with none pending: row %0d col %0d value %0d",
                       got.out_row, got.out_col, got.conv_value));
      return;
    end
    want = expected_results.pop_front();
    if (got.out_row !== want.out_row)
      report($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
    if (got.out_col !== want.out_col)
      report($sformatf("out_col %0d, want %0d (row %0d)", got.out_col, want.out_col,
                       want.out_row));
    if (got.conv_value !== want.conv_value)
      report($sformatf("conv_value %0d, want %0d at row %0d col %0d", got.conv_value,
                       want.conv_value, want.out_row, want.out_col));
    if (got.frame_last !== want.frame_last)
      report($sformatf("frame_last %b, want %b at row %0d col %0d", got.frame_last,
                       want.frame_last, want.out_row, want.out_col));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int i;
    int j;
    if (!rst_ni) begin
      width_reg  = SIZE_CFG_W'(WIDTH_RST);
      height_reg = SIZE_CFG_W'(HEIGHT_RST);
      for (i = 0; i < KSIZE; i++) begin
        coef_rows[i] = '0;
        for (j = 0; j < KSIZE; j++) win[i][j] = '0;
      end
      for (i = 0; i < 2; i++) begin
        for (j = 0; j < MAX_WIDTH; j++) line_mem[i][j] = '0;
      end
      row_cnt = 0;
      col_cnt = 0;
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (res_valid_i && res_ready_i) check_result(res_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IMAGE_WIDTH:  width_reg    = cfg_data_i[SIZE_CFG_W-1:0];
          CFG_IMAGE_HEIGHT: height_reg   = cfg_data_i[SIZE_CFG_W-1:0];
          CFG_COEF_TOP:     coef_rows[0] = cfg_data_i;
          CFG_COEF_MID:     coef_rows[1] = cfg_data_i;
          CFG_COEF_BOTTOM:  coef_rows[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (pix_valid_i && pix_ready_i) take_pixel(pix_data_i.pixel);
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// tb_top: stimulus and verdict for conv2d_3x3_stream.
// Drives pixels and register writes, stalls the result sink, and relies on
// conv3x3_checker (plus c3s_pkg and c3s_stream_if) for all result checking.
module tb_top;
  import c3s_pkg::*;

  // Widest row of the random phases. One frame three rows tall at this
  // width writes every line memory entry those phases can reach.
  localparam int WIDE_ROW        = 96;
  // Pixels sent into the top of the tallest frame.
  localparam int TALL_PIXELS     = 60;
  localparam int RANDOM_ITEMS    = 1000;
  // Pipeline depth plus margin: lets pixels that emit nothing
  // leave the pipeline before the registers change.
  localparam int SETTLE_CYCLES   = 16;
  localparam int IDLE_LIMIT      = 4000;

  localparam logic [SIZE_CFG_W-1:0] SIZE_FIELD_MAX = '1;
  localparam logic [PIXEL_W-1:0]    PIXEL_MAX      = '1;
  localparam logic [COEF_SLOT-1:0]  COEF_MOST_NEG  = {1'b1, {(COEF_SLOT-1){1'b0}}};
  localparam logic [COEF_SLOT-1:0]  COEF_MOST_POS  = {1'b0, {(COEF_SLOT-1){1'b1}}};

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_e;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [COEF_ROW_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending_results;
  int                    burst_left;
  int                    idle_cycles;

  c3s_stream_if #(.T(pix_t)) pix_ch ();
  c3s_stream_if #(.T(res_t)) res_ch ();

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  conv2d_3x3_stream dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_ch),
    .res_o      (res_ch)
  );

  conv3x3_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pix_valid_i  (pix_ch.valid),
    .pix_ready_i  (pix_ch.ready),
    .pix_data_i   (pix_ch.data),
    .res_valid_i  (res_ch.valid),
    .res_ready_i  (res_ch.ready),
    .res_data_i   (res_ch.data),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  // Drive one register write; hold the enable high so back-to-back writes
  // never lower and raise it in the same step. close_writes drops it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [COEF_ROW_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
  endtask

  task automatic close_writes();
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    @(negedge clk);
  endtask

  task automatic write_kernel(input logic [COEF_ROW_W-1:0] top_row,
                              input logic [COEF_ROW_W-1:0] mid_row,
                              input logic [COEF_ROW_W-1:0] bottom_row);
    write_reg(CFG_COEF_TOP, top_row);
    write_reg(CFG_COEF_MID, mid_row);
    write_reg(CFG_COEF_BOTTOM, bottom_row);
  endtask

  // Size writes carry random junk above the 11-bit field; the block must
  // drop it.
  function automatic logic [COEF_ROW_W-1:0] size_word(input int unsigned dim);
    logic [COEF_ROW_W-1:0] word;
    word = COEF_ROW_W'({$urandom, $urandom});
    word[SIZE_CFG_W-1:0] = SIZE_CFG_W'(dim);
    return word;
  endfunction

  // Bias each coefficient slot toward its extremes and toward -1 and 0.
  function automatic logic [COEF_ROW_W-1:0] rand_kernel_row();
    logic [COEF_ROW_W-1:0] row;
    logic [COEF_SLOT-1:0]  slot;
    int                    k;
    for (k = 0; k < KSIZE; k++) begin
      case ($urandom_range(0, 7))
        0:       slot = COEF_MOST_NEG;
        1:       slot = COEF_MOST_POS;
        2:       slot = '0;
        3:       slot = '1;
        4:       slot = COEF_SLOT'($urandom_range(0, 15));
        default: slot = COEF_SLOT'($urandom);
      endcase
      row[k*COEF_SLOT +: COEF_SLOT] = slot;
    end
    return row;
  endfunction

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PIXEL_MAX;
      default: return PIXEL_W'($urandom);
    endcase
  endfunction

  // Mostly narrow frames so results come often; a few below the minimum
  // (clamped) and a few wider rows.
  function automatic int unsigned rand_width();
    case ($urandom_range(0, 19))
      0, 1:    return $urandom_range(0, SIZE_MIN - 1);
      2, 3, 4: return $urandom_range(11, 40);
      5:       return $urandom_range(41, WIDE_ROW);
      default: return $urandom_range(SIZE_MIN, 10);
    endcase
  endfunction

  function automatic int unsigned rand_height();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, SIZE_MIN - 1);
      1, 2:    return $urandom_range(9, 16);
      default: return $urandom_range(SIZE_MIN, 8);
    endcase
  endfunction

  function automatic logic [CFG_IDX_W-1:0] unused_index();
    return CFG_IDX_W'($urandom_range(int'(CFG_COEF_BOTTOM) + 1, (1 << CFG_IDX_W) - 1));
  endfunction

  // Offer one pixel. The sender runs in bursts: when a burst is used up,
  // drop valid for a random gap (sometimes none) and draw a new burst length.
  // Hold valid and data until the transaction at a rising edge, then
  // return at the next falling edge.
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        pix_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 40);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.data  <= px;
    do @(posedge clk); while (!pix_ch.ready);
    @(negedge clk);
    burst_left--;
  endtask

  // Stop the sender, wait for every expected result, then let pixels that
  // emit nothing clear the pipeline so the registers can change safely.
  task automatic drain();
    pix_ch.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Result sink: switch between stall modes over spans of random length, from
  // fully open to mostly stalled, so back-pressure reaches the pixel side.
  initial begin
    sink_mode_e mode;
    int         span;
    int         period;
    int         k;
    res_ch.ready = 1'b0;
    forever begin
      mode   = sink_mode_e'($urandom_range(0, 3));
      span   = $urandom_range(40, 200);
      period = $urandom_range(2, 8);
      for (k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          SINK_OPEN:   res_ch.ready <= 1'b1;
          SINK_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     res_ch.ready <= ((k / period) % 2 == 0);
        endcase
      end
    end
  end

  // Watchdog: end the run if no transaction and no register write happens
  // for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (pix_ch.valid && pix_ch.ready) ||
        (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int random_sent;
    int count;
    int k;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    pix_ch.valid = 1'b0;
    pix_ch.data  = '0;
    burst_left   = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: smallest frame, sizes below the minimum (both clamp to 3).
    // All-white frame against the most negative kernel gives the lowest sum.
    write_reg(CFG_IMAGE_WIDTH, size_word(0));
    write_reg(CFG_IMAGE_HEIGHT, size_word(SIZE_MIN - 1));
    write_kernel({KSIZE{COEF_MOST_NEG}}, {KSIZE{COEF_MOST_NEG}}, {KSIZE{COEF_MOST_NEG}});
    close_writes();
    repeat (9) send_pixel(PIXEL_MAX);
    drain();

    // Highest sum on the next frame back to back; a write to an index past
    // the last register must change nothing.
    write_kernel({KSIZE{COEF_MOST_POS}}, {KSIZE{COEF_MOST_POS}}, {KSIZE{COEF_MOST_POS}});
    write_reg(unused_index(), '1);
    close_writes();
    repeat (9) send_pixel(PIXEL_MAX);
    drain();

    // Mixed kernel over a black and white checker pattern, so the tap positions
    // under white pixels show in the sum.
    write_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
    close_writes();
    for (k = 0; k < 9; k++) send_pixel(k[0] ? PIXEL_MAX : '0);
    drain();

    // Full frame three rows tall at the widest random row. This writes
    // every line memory entry the random phases can reach, so later size
    // changes in mid-frame never read an entry that was never written.
    write_reg(CFG_IMAGE_WIDTH, size_word(WIDE_ROW));
    write_reg(CFG_IMAGE_HEIGHT, size_word(SIZE_MIN));
    write_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
    close_writes();
    repeat (KSIZE * WIDE_ROW) send_pixel(rand_pixel());
    drain();

    // Tallest frame: height field all ones clamps to the maximum height.
    // Run only its top rows; the random phases take over in mid-frame.
    write_reg(CFG_IMAGE_WIDTH, size_word(1));
    write_reg(CFG_IMAGE_HEIGHT, size_word(SIZE_FIELD_MAX));
    close_writes();
    repeat (TALL_PIXELS) send_pixel(rand_pixel());
    drain();

    // Random phases: new sizes and kernels between bursts of pixels. Phase
    // lengths do not match frame sizes, so sizes change in mid-frame too.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      count = $urandom_range(20, 150);
      if ($urandom_range(0, 3) != 0) write_reg(CFG_IMAGE_WIDTH, size_word(rand_width()));
      if ($urandom_range(0, 3) != 0) write_reg(CFG_IMAGE_HEIGHT, size_word(rand_height()));
      for (k = 0; k < KSIZE; k++) begin
        if ($urandom_range(0, 2) == 0)
          write_reg(CFG_IDX_W'(int'(CFG_COEF_TOP) + k), rand_kernel_row());
      end
      if ($urandom_range(0, 5) == 0)
        write_reg(unused_index(), COEF_ROW_W'({$urandom, $urandom}));
      close_writes();
      repeat (count) send_pixel(rand_pixel());
      random_sent += count;
      drain();
    end

    if (fail_count == 0 && pending_results == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== conv2d_3x3_stream.f =====
rtl/core/c3s_pkg.sv
rtl/core/c3s_stream_if.sv
rtl/core/conv2d_3x3_stream.sv
dv/conv3x3_checker.sv
dv/tb_top.sv
